### rtl/core/swta_pkg.sv
package swta_pkg;

  localparam int NEURONS = 16;
  localparam int DIM     = 16;
  localparam int WORDS   = NEURONS * DIM;

  localparam int NAW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int EAW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int WAW = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam logic [15:0] LEARN_RATE_RESET = 16'd19661;

  typedef struct packed {
    logic               opcode;
    logic [7:0]         neuron_index;
    logic [5:0]         element_index;
    logic signed [15:0] sample_value;
    logic               last_element;
  } req_t;

  typedef struct packed {
    logic [7:0]  winner_index;
    logic [36:0] winner_score;
  } res_t;

  typedef enum logic [1:0] {
    K_WEIGHT = 2'd0,
    K_ELEM   = 2'd1,
    K_SEARCH = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               store;
    logic [WAW-1:0]     waddr;
    logic [EAW-1:0]     elem;
    logic signed [15:0] value;
  } cmd_t;

  localparam logic OP_WEIGHT = 1'b0;

endpackage

### rtl/core/swta_front.sv
module swta_front import swta_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  localparam int QD = 4;

  cmd_t       q_mem [QD];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  cmd_t       cls;
  logic       push;
  logic       pop;

  // classify the request and form the store address
  always_comb begin
    cls.value = in_data.sample_value;
    cls.elem  = EAW'(in_data.element_index);
    cls.waddr = WAW'(int'(in_data.neuron_index) * DIM + int'(in_data.element_index));
    if (in_data.opcode == OP_WEIGHT) begin
      cls.kind  = K_WEIGHT;
      cls.store = (int'(in_data.neuron_index) < NEURONS) &&
                  (int'(in_data.element_index) < DIM);
    end else begin
      cls.kind  = in_data.last_element ? K_SEARCH : K_ELEM;
      cls.store = int'(in_data.element_index) < DIM;
    end
  end

  assign in_ready  = count != 3'(QD);
  assign cmd_valid = count != 3'd0;
  assign cmd       = q_mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

### rtl/core/swta_back.sv
module swta_back import swta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_data
);

  localparam int SW    = 38;
  localparam int SQ_IT = SW / 2;
  localparam int SCW   = $clog2(SQ_IT);
  localparam int NRW   = SQ_IT;
  localparam int DVW   = 29;
  localparam int DCW   = $clog2(DVW);

  typedef enum logic [3:0] {
    S_IDLE, S_DOT, S_DRAIN, S_UPD_RD, S_UPD_MUL, S_UPD_ADD, S_UPD_SQ, S_UPD_ACC,
    S_SQRT, S_SQ_END, S_NRM_RD, S_NRM_LOAD, S_NRM_DIV, S_NRM_WR, S_DONE
  } state_t;

  state_t state;

  logic signed [15:0] wmem [WORDS];
  logic signed [15:0] xbuf [DIM];
  logic signed [15:0] w_rd;
  logic signed [15:0] x_rd;

  logic               mem_we;
  logic [WAW-1:0]     mem_waddr;
  logic signed [15:0] mem_wdata;
  logic [WAW-1:0]     mem_raddr;

  logic [15:0]        learn_rate;
  logic [WAW-1:0]     rd_cnt;
  logic [EAW-1:0]     e_cnt;
  logic [NAW-1:0]     n_cnt;

  logic               p1_v, p1_last, p2_v, p2_last;
  logic [NAW-1:0]     p1_n, p2_n;
  logic signed [31:0] prod;
  logic signed [SW-1:0] acc, best, dot_sum;
  logic [NAW-1:0]     winner;

  logic [WAW-1:0]     upd_base, upd_addr;
  logic signed [33:0] t_mul;
  logic signed [15:0] w_hold, wn_q, wn;
  logic signed [17:0] delta, wn_wide;
  logic signed [16:0] diff;
  logic signed [31:0] sq;
  logic [SW-1:0]      s_acc;

  logic [SW-1:0]      sq_v, sq_res, sq_bit, sq_sum;
  logic [SCW-1:0]     sq_cnt;
  logic [NRW-1:0]     norm;

  logic [DVW-1:0]     num, quo;
  logic [NRW-1:0]     rem;
  logic [NRW:0]       rem_sh;
  logic [DCW-1:0]     dv_cnt;
  logic               neg;
  logic [15:0]        mag;
  logic signed [15:0] nrm_val;

  assign cmd_ready = state == S_IDLE;

  assign diff    = 17'(x_rd) - 17'(w_rd);
  assign delta   = 18'((t_mul + 34'sd32768) >>> 16);
  assign wn_wide = 18'(w_hold) + delta;
  always_comb begin
    if (wn_wide > 18'sd32767) wn = 16'sd32767;
    else if (wn_wide < -18'sd32768) wn = -16'sd32768;
    else wn = 16'(wn_wide);
  end

  assign sq_sum  = sq_res + sq_bit;
  assign rem_sh  = {rem, num[DVW-1]};
  assign mag     = w_rd[15] ? 16'(-w_rd) : 16'(w_rd);
  assign dot_sum = acc + SW'(prod);

  always_comb begin
    if (neg) nrm_val = (quo >= DVW'(32768)) ? -16'sd32768 : -$signed(16'(quo));
    else nrm_val = (quo > DVW'(32767)) ? 16'sd32767 : $signed(16'(quo));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = upd_addr;
    mem_wdata = wn;
    mem_raddr = (state == S_DOT) ? rd_cnt : upd_addr;
    case (state)
      S_IDLE: begin
        mem_we    = cmd_valid && cmd.kind == K_WEIGHT && cmd.store;
        mem_waddr = cmd.waddr;
        mem_wdata = cmd.value;
      end
      S_UPD_ADD: mem_we = 1'b1;
      S_NRM_WR: begin
        mem_we    = 1'b1;
        mem_wdata = nrm_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) wmem[mem_waddr] <= mem_wdata;
    w_rd <= wmem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid && cmd.kind != K_WEIGHT && cmd.store) begin
      xbuf[cmd.elem] <= cmd.value;
    end
    x_rd <= xbuf[e_cnt];
  end

  always_ff @(posedge clk) begin
    // dot product pipeline: read, multiply, accumulate
    p1_v    <= state == S_DOT;
    p1_last <= e_cnt == EAW'(DIM - 1);
    p1_n    <= n_cnt;
    p2_v    <= p1_v;
    p2_last <= p1_last;
    p2_n    <= p1_n;
    prod    <= w_rd * x_rd;
    if (p2_v) begin
      if (p2_last) begin
        acc <= '0;
        if (dot_sum > best) begin
          best   <= dot_sum;
          winner <= p2_n;
        end
      end else begin
        acc <= dot_sum;
      end
    end
    if (out_ready) out_valid <= 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_valid && cmd.kind == K_SEARCH) begin
          rd_cnt <= '0;
          e_cnt  <= '0;
          n_cnt  <= '0;
          acc    <= '0;
          best   <= '0;
          winner <= '0;
          state  <= S_DOT;
        end
      end
      S_DOT: begin
        rd_cnt <= rd_cnt + 1'b1;
        if (e_cnt == EAW'(DIM - 1)) begin
          e_cnt <= '0;
          n_cnt <= n_cnt + 1'b1;
        end else begin
          e_cnt <= e_cnt + 1'b1;
        end
        if (rd_cnt == WAW'(WORDS - 1)) state <= S_DRAIN;
      end
      S_DRAIN: begin
        if (!p1_v && !p2_v) begin
          upd_base <= WAW'(int'(winner) * DIM);
          upd_addr <= WAW'(int'(winner) * DIM);
          e_cnt    <= '0;
          s_acc    <= '0;
          state    <= S_UPD_RD;
        end
      end
      S_UPD_RD: state <= S_UPD_MUL;
      S_UPD_MUL: begin
        t_mul  <= $signed({1'b0, learn_rate}) * diff;
        w_hold <= w_rd;
        state  <= S_UPD_ADD;
      end
      S_UPD_ADD: begin
        wn_q  <= wn;
        state <= S_UPD_SQ;
      end
      S_UPD_SQ: begin
        sq    <= wn_q * wn_q;
        state <= S_UPD_ACC;
      end
      S_UPD_ACC: begin
        s_acc <= s_acc + SW'($unsigned(sq));
        if (e_cnt == EAW'(DIM - 1)) begin
          e_cnt  <= '0;
          sq_v   <= s_acc + SW'($unsigned(sq));
          sq_res <= '0;
          sq_bit <= SW'(1) << (SW - 2);
          sq_cnt <= '0;
          state  <= S_SQRT;
        end else begin
          e_cnt    <= e_cnt + 1'b1;
          upd_addr <= upd_addr + 1'b1;
          state    <= S_UPD_RD;
        end
      end
      S_SQRT: begin
        if (sq_v >= sq_sum) begin
          sq_v   <= sq_v - sq_sum;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt + 1'b1;
        if (sq_cnt == SCW'(SQ_IT - 1)) state <= S_SQ_END;
      end
      S_SQ_END: begin
        norm     <= NRW'(sq_res);
        upd_addr <= upd_base;
        state    <= (sq_res == '0) ? S_DONE : S_NRM_RD;
      end
      S_NRM_RD: state <= S_NRM_LOAD;
      S_NRM_LOAD: begin
        num    <= DVW'({mag, 12'd0}) + DVW'(norm >> 1);
        neg    <= w_rd[15];
        rem    <= '0;
        quo    <= '0;
        dv_cnt <= '0;
        state  <= S_NRM_DIV;
      end
      S_NRM_DIV: begin
        if (rem_sh >= {1'b0, norm}) begin
          rem <= NRW'(rem_sh - {1'b0, norm});
          quo <= {quo[DVW-2:0], 1'b1};
        end else begin
          rem <= NRW'(rem_sh);
          quo <= {quo[DVW-2:0], 1'b0};
        end
        num    <= num << 1;
        dv_cnt <= dv_cnt + 1'b1;
        if (dv_cnt == DCW'(DVW - 1)) state <= S_NRM_WR;
      end
      S_NRM_WR: begin
        if (e_cnt == EAW'(DIM - 1)) begin
          state <= S_DONE;
        end else begin
          e_cnt    <= e_cnt + 1'b1;
          upd_addr <= upd_addr + 1'b1;
          state    <= S_NRM_RD;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid             <= 1'b1;
          out_data.winner_index <= 8'(winner);
          out_data.winner_score <= best[36:0];
          state                 <= S_IDLE;
        end
      end
      default: state <= S_IDLE;
    endcase
    if (cfg_we) learn_rate <= cfg_wdata;
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      p1_v       <= 1'b0;
      p2_v       <= 1'b0;
      best       <= '0;
      learn_rate <= LEARN_RATE_RESET;
    end
  end

  a_best_nonneg: assert property (@(posedge clk) disable iff (rst) !best[SW-1])
    else $error("running maximum went negative");
  a_pipe_in_dot: assert property (@(posedge clk) disable iff (rst)
    p2_v |-> (state == S_DOT || state == S_DRAIN))
    else $error("dot pipeline busy outside search");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside completion");
  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_NRM_DIV || state == S_NRM_WR) |-> norm != '0)
    else $error("division by zero norm");

endmodule

### rtl/core/som_winner_take_all_learning.sv
// competitive layer with winner-take-all learning
// in channel (in_valid/in_ready/in_data): opcode 0 writes one weight word,
// opcode 1 stores one input element; an element marked last starts a search
// out channel (out_valid/out_ready/out_data): winner index and winning score,
// one result per search
// cfg_we/cfg_wdata load the learning rate (Q0.16); the user must do so only
// while the block is idle, as the block does not enforce it; requests pass a
// four-entry queue, so up to four are taken while the engine works; weight
// and plain element requests are handled by the engine in its idle state
// a search runs one multiplier over the single weight memory read port, then
// a bit-per-cycle square root and, if the norm is nonzero, a bit-per-cycle
// divider per element; the result waits in an output register; a stalled
// receiver holds the engine at completion while the queue keeps filling
// reset (rst, synchronous) empties the queue, drops any result and sets the
// learning rate to 0.3; weights and inputs must be written before use
module som_winner_take_all_learning import swta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  swta_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  swta_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import swta_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_data;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  som_winner_take_all_learning DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  localparam int SEARCH_CYCLES = NEURONS * DIM + 37 * DIM + 24;
  localparam int SETTLE_CYCLES = 4 * SEARCH_CYCLES;
  localparam int STALL_LIMIT = 20000;

  req_t pending_requests[$];
  res_t expected_winners[$];
  logic signed [15:0] weight_mem[WORDS];
  logic signed [15:0] input_vec[DIM];
  logic [15:0] rate_q = LEARN_RATE_RESET;
  int errors = 0;
  int cycle_count = 0;
  int items_queued = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [15:0] clamp_word(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, bit_v;
    res = 0;
    bit_v = 64'sd1 <<< 60;
    while (bit_v > v) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >>> 1) + bit_v;
      end else begin
        res = res >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  // move the winner toward the input, then rescale to unit length
  function automatic void train_winner(int n);
    longint d, delta, s, norm, v, mag, q;
    s = 0;
    for (int e = 0; e < DIM; e++) begin
      d = longint'(input_vec[e]) - longint'(weight_mem[n * DIM + e]);
      delta = (longint'(rate_q) * d + 32768) >>> 16;
      weight_mem[n * DIM + e] = clamp_word(longint'(weight_mem[n * DIM + e]) + delta);
    end
    for (int e = 0; e < DIM; e++) begin
      v = weight_mem[n * DIM + e];
      s += v * v;
    end
    norm = int_sqrt(s);
    if (norm == 0) return;
    for (int e = 0; e < DIM; e++) begin
      v = weight_mem[n * DIM + e];
      mag = (v < 0) ? -v : v;
      q = (mag * 4096 + (norm >>> 1)) / norm;
      weight_mem[n * DIM + e] = clamp_word((v < 0) ? -q : q);
    end
  endfunction

  function automatic void predict_request(req_t r);
    longint best, p;
    int win;
    res_t res;
    if (r.opcode == OP_WEIGHT) begin
      if (r.neuron_index < NEURONS && r.element_index < DIM)
        weight_mem[r.neuron_index * DIM + r.element_index] = r.sample_value;
      return;
    end
    if (r.element_index < DIM) input_vec[r.element_index] = r.sample_value;
    if (!r.last_element) return;
    best = 0;
    win = 0;
    for (int n = 0; n < NEURONS; n++) begin
      p = 0;
      for (int e = 0; e < DIM; e++)
        p += longint'(input_vec[e]) * longint'(weight_mem[n * DIM + e]);
      if (p > best) begin
        best = p;
        win = n;
      end
    end
    train_winner(win);
    res.winner_index = win[7:0];
    res.winner_score = best[36:0];
    expected_winners.push_back(res);
  endfunction

  function automatic logic take_turn();
    if (cycle_count > 30000 && cycle_count < 60000) return 1'b1;
    return $urandom_range(99) >= 14;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && take_turn()) begin
          in_valid <= 1'b1;
          in_data <= pending_requests.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= take_turn();
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_request(in_data);
      if (out_valid && out_ready) begin
        if (expected_winners.size() == 0) begin
          report_mismatch("unexpected result index", out_data.winner_index, -1);
        end else begin
          res_t want;
          want = expected_winners.pop_front();
          if (out_data.winner_index !== want.winner_index)
            report_mismatch("winner_index", out_data.winner_index, want.winner_index);
          if (out_data.winner_score !== want.winner_score)
            report_mismatch("winner_score", out_data.winner_score, want.winner_score);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_request(logic op, int n, int e, int v, logic last);
    req_t r;
    r.opcode = op;
    r.neuron_index = n[7:0];
    r.element_index = e[5:0];
    r.sample_value = v[15:0];
    r.last_element = last;
    @(negedge clk);
    pending_requests.push_back(r);
    items_queued++;
  endtask

  function automatic int rand_sample(int mode);
    case (mode)
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(8192) - 4096;
      2: return -$urandom_range(32768);
      default: return $urandom_range(32767);
    endcase
  endfunction

  task automatic send_vector(int mode);
    int order[DIM];
    int j, t;
    for (int e = 0; e < DIM; e++) order[e] = e;
    if ($urandom_range(1)) begin
      for (int e = DIM - 1; e > 0; e--) begin
        j = $urandom_range(e);
        t = order[e]; order[e] = order[j]; order[j] = t;
      end
    end
    for (int e = 0; e < DIM; e++)
      push_request(~OP_WEIGHT, $urandom_range(255), order[e], rand_sample(mode), e == DIM - 1);
  endtask

  // every request accepted and every result back, so the engine is idle
  task automatic drain_and_set_rate(logic [15:0] v);
    wait (pending_requests.size() == 0 && !in_valid && expected_winners.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rate_q = v;
  endtask

  task automatic random_phase(int count);
    int stop_at;
    stop_at = items_queued + count;
    while (items_queued < stop_at) begin
      case ($urandom_range(19))
        0: push_request(OP_WEIGHT, $urandom_range(255), $urandom_range(63),
                        rand_sample(0), $urandom_range(1));
        1: push_request(OP_WEIGHT, $urandom_range(NEURONS - 1), $urandom_range(DIM - 1),
                        rand_sample(1), $urandom_range(1));
        2: push_request(~OP_WEIGHT, $urandom_range(255), $urandom_range(63),
                        rand_sample(0), 1'b0);
        3: push_request(~OP_WEIGHT, $urandom_range(255), $urandom_range(63, DIM),
                        rand_sample(0), $urandom_range(3) == 0);
        default: send_vector($urandom_range(3));
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // rate written once right away while idle
    drain_and_set_rate(LEARN_RATE_RESET);
    for (int n = 0; n < NEURONS; n++)
      for (int e = 0; e < DIM; e++)
        push_request(OP_WEIGHT, n, e, rand_sample($urandom_range(1)), $urandom_range(1));
    // extremes, out of range writes, last flag on a weight write
    push_request(OP_WEIGHT, 1, 0, 32767, 1'b1);
    push_request(OP_WEIGHT, 2, DIM - 1, -32768, 1'b0);
    push_request(OP_WEIGHT, 255, 63, -1, 1'b1);
    push_request(OP_WEIGHT, NEURONS, 3, 1234, 1'b0);
    push_request(OP_WEIGHT, 0, DIM, 777, 1'b0);
    for (int e = 0; e < DIM; e++) push_request(~OP_WEIGHT, 255, e, 32767, e == DIM - 1);
    for (int e = 0; e < DIM; e++) push_request(~OP_WEIGHT, 0, e, -32768, e == DIM - 1);
    // zero weights for neuron 0 and zero input: no positive product, zero norm
    for (int e = 0; e < DIM; e++) push_request(OP_WEIGHT, 0, e, 0, 1'b0);
    for (int e = 0; e < DIM; e++) push_request(~OP_WEIGHT, 0, e, 0, 1'b0);
    push_request(~OP_WEIGHT, 170, 63, 5, 1'b1);
    random_phase(180);
    drain_and_set_rate(16'd0);
    random_phase(160);
    drain_and_set_rate(16'hFFFF);
    random_phase(180);
    drain_and_set_rate($urandom_range(65535));
    random_phase(180);
    drain_and_set_rate(16'd1);
    random_phase(160);
    wait (pending_requests.size() == 0 && !in_valid && expected_winners.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_winners.size() != 0) errors++;
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### som_winner_take_all_learning.f
rtl/core/swta_pkg.sv
rtl/core/swta_front.sv
rtl/core/swta_back.sv
rtl/core/som_winner_take_all_learning.sv
sim/tb_top.sv
